### hw/rtl/cigar_region_interval_locator_unit_defines.svh
// Assertion macros shared by the locator RTL.
// No dependencies; included by modules that carry checks.
`ifndef CIGAR_REGION_INTERVAL_LOCATOR_UNIT_DEFINES_SVH
`define CIGAR_REGION_INTERVAL_LOCATOR_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CRIL_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define CRIL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define CRIL_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define CRIL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/cril_pkg.sv
// Types, codes and helpers for the CIGAR region interval locator.
// No dependencies.
package cril_pkg;
	localparam logic [3:0] OP_M = 4'd0;
	localparam logic [3:0] OP_I = 4'd1;
	localparam logic [3:0] OP_D = 4'd2;
	localparam logic [3:0] OP_N = 4'd3;
	localparam logic [3:0] OP_S = 4'd4;
	localparam logic [3:0] OP_EQ = 4'd7;
	localparam logic [3:0] OP_X = 4'd8;

	localparam logic [1:0] ST_NONE = 2'd0;
	localparam logic [1:0] ST_VALID = 2'd1;
	localparam logic [1:0] ST_START_ONLY = 2'd2;
	localparam logic [1:0] ST_END_ONLY = 2'd3;

	localparam logic [1:0] REG_REGION_START = 2'd0;
	localparam logic [1:0] REG_REGION_END = 2'd1;
	localparam logic [1:0] REG_READ_LENGTH = 2'd2;

	localparam logic signed [33:0] WINDOW = 34'sd250;
	localparam logic signed [31:0] OUT_MAX = 32'sd16777215;
	localparam logic signed [31:0] NO_POS = -32'sd1;

	typedef struct packed {
		logic [27:0] len;
		logic        first;
		logic [31:0] aln_ref_start;
		logic        flipped;
		logic        close_aln;
		logic        last_rec;
		logic        eats_read;
		logic        eats_ref;
		logic        is_match;
	} cril_op_t;

	function automatic logic [33:0] mag34(input logic signed [33:0] v);
		mag34 = v[33] ? 34'(-v) : 34'(v);
	endfunction

	// reflect a read position onto the opposite strand
	function automatic logic signed [31:0] mirror(input logic signed [31:0] p,
		input logic [23:0] rlen);
		if (p < 0) mirror = p;
		else mirror = $signed({8'd0, rlen} - 32'(p) - 32'd1);
	endfunction
endpackage

### hw/rtl/cril_if.sv
// Valid/ready channels for CIGAR operations and interval results.
// Depends on nothing.
interface cril_item_if;
	logic        valid;
	logic        ready;
	logic [3:0]  op_kind;
	logic [27:0] op_len;
	logic        first_of_alignment;
	logic [31:0] aln_ref_start;
	logic        aln_flipped;
	logic        last_of_alignment;
	logic        last_of_record;
	modport source(output valid, op_kind, op_len, first_of_alignment, aln_ref_start,
		aln_flipped, last_of_alignment, last_of_record, input ready);
	modport sink(input valid, op_kind, op_len, first_of_alignment, aln_ref_start,
		aln_flipped, last_of_alignment, last_of_record, output ready);
endinterface

interface cril_result_if;
	logic               valid;
	logic               ready;
	logic signed [24:0] interval_start;
	logic signed [24:0] interval_end;
	logic [1:0]         status;
	modport source(output valid, interval_start, interval_end, status, input ready);
	modport sink(input valid, interval_start, interval_end, status, output ready);
endinterface

### hw/rtl/cril_front.sv
// Front end: accepts CIGAR operations and classifies them by consumption.
// Depends on cril_pkg and cril_item_if.
module cril_front (
	cril_item_if.sink         item_in,
	input  logic              q_ready,
	output logic              push,
	output cril_pkg::cril_op_t push_op
);
	import cril_pkg::*;

	logic [3:0] kind;

	assign kind = item_in.op_kind;
	assign item_in.ready = q_ready;
	assign push = item_in.valid & q_ready;

	always_comb begin
		push_op.len = item_in.op_len;
		push_op.first = item_in.first_of_alignment;
		push_op.aln_ref_start = item_in.aln_ref_start;
		push_op.flipped = item_in.aln_flipped;
		push_op.close_aln = item_in.last_of_alignment | item_in.last_of_record;
		push_op.last_rec = item_in.last_of_record;
		push_op.eats_read = (kind == OP_M) || (kind == OP_I) || (kind == OP_S) ||
			(kind == OP_EQ) || (kind == OP_X);
		push_op.eats_ref = (kind == OP_M) || (kind == OP_D) || (kind == OP_N) ||
			(kind == OP_EQ) || (kind == OP_X);
		push_op.is_match = (kind == OP_M) || (kind == OP_EQ);
	end
endmodule

### hw/rtl/cril_queue.sv
// Small FIFO of classified operations between front and back end.
// Depends on cril_pkg and the assertion macro header.
`include "cigar_region_interval_locator_unit_defines.svh"
module cril_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  cril_pkg::cril_op_t push_op,
	output logic               not_full,
	input  logic               pop,
	output logic               not_empty,
	output cril_pkg::cril_op_t pop_op
);
	import cril_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cril_op_t        slot_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign not_full = count_q != CW'(DEPTH);
	assign not_empty = count_q != '0;
	assign pop_op = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	`CRIL_ASSERT_IMPLY(a_no_overflow, clk, arst_n, push, not_full)
	`CRIL_ASSERT_IMPLY(a_no_underflow, clk, arst_n, pop, not_empty)
	`CRIL_ASSERT_IMPLY(a_count_range, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
endmodule

### hw/rtl/cril_back.sv
// Back end: running positions and op distances in a first stage, best distances and record interval in a second.
// Depends on cril_pkg, cril_result_if and the assertion macro header.
`include "cigar_region_interval_locator_unit_defines.svh"
module cril_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [31:0]        region_start,
	input  logic [31:0]        region_end,
	input  logic [23:0]        read_length,
	input  logic               op_avail,
	input  cril_pkg::cril_op_t op,
	output logic               pop,
	cril_result_if.source      result_out
);
	import cril_pkg::*;

	logic [31:0]        ref_q, read_q;
	logic               rec_open_q;
	logic               vld_s1, open_s1, first_s1, match_s1, close_s1, last_s1, flip_s1;
	logic               nsd_ok_s1, ned_ok_s1;
	logic [33:0]        nsd_mag_s1, ned_mag_s1, bsd_mag_s1, bed_mag_s1;
	logic signed [31:0] cand_new_s_s1, cand_new_e_s1;
	logic [33:0]        best_s_mag_q, best_e_mag_q;
	logic signed [31:0] cand_s_q, cand_e_q, rec_s_q, rec_e_q;
	logic               out_vld_q;
	logic signed [24:0] out_start_q, out_end_q;
	logic [1:0]         out_status_q;

	logic               open_now, first;
	logic [31:0]        ref_new, read_new;
	logic signed [33:0] ds, de, sc, ec, nsd, ned, len34;
	logic               stall_b, adv_b;
	logic [33:0]        best_s_mag0, best_e_mag0, best_s_mag_nx, best_e_mag_nx;
	logic signed [31:0] cand_s0, cand_e0, rec_s0, rec_e0;
	logic               upd_s, upd_e;
	logic signed [31:0] cand_s_nx, cand_e_nx, sp, ep, rec_s_nx, rec_e_nx;
	logic               win_s, win_e;
	logic signed [24:0] res_start, res_end;
	logic [1:0]         res_status;

	// first stage: positions and the distances of this operation
	always_comb begin
		open_now = !rec_open_q;
		first = op.first | open_now;
		ref_new = (first ? op.aln_ref_start : ref_q) +
			(op.eats_ref ? {4'd0, op.len} : 32'd0);
		read_new = (first ? 32'd0 : read_q) + (op.eats_read ? {4'd0, op.len} : 32'd0);

		len34 = $signed({6'd0, op.len});
		ds = $signed({2'b00, ref_new}) - $signed({2'b00, region_start});
		de = $signed({2'b00, ref_new}) - $signed({2'b00, region_end});
		sc = (ds > 0) ? ((len34 < ds) ? len34 : ds) : 34'sd1;
		ec = (de <= 0) ? 34'sd1 : ((len34 < de) ? len34 : de);
		nsd = ds - sc;
		ned = de - ec;
	end

	// second stage: best distances, candidates and the record merge
	always_comb begin
		best_s_mag0 = open_s1 ? {10'd0, read_length} : best_s_mag_q;
		best_e_mag0 = open_s1 ? {10'd0, read_length} : best_e_mag_q;
		rec_s0 = open_s1 ? NO_POS : rec_s_q;
		rec_e0 = open_s1 ? NO_POS : rec_e_q;
		cand_s0 = first_s1 ? NO_POS : cand_s_q;
		cand_e0 = first_s1 ? NO_POS : cand_e_q;

		upd_s = match_s1 && nsd_ok_s1 && (nsd_mag_s1 <= best_s_mag0);
		upd_e = match_s1 && ned_ok_s1 && (ned_mag_s1 <= best_e_mag0);
		cand_s_nx = upd_s ? cand_new_s_s1 : cand_s0;
		cand_e_nx = upd_e ? cand_new_e_s1 : cand_e0;
		best_s_mag_nx = upd_s ? bsd_mag_s1 : best_s_mag0;
		best_e_mag_nx = upd_e ? bed_mag_s1 : best_e_mag0;

		// swap and reflect when the alignment runs against the primary strand
		sp = flip_s1 ? mirror(cand_e_nx, read_length) : cand_s_nx;
		ep = flip_s1 ? mirror(cand_s_nx, read_length) : cand_e_nx;
		win_s = best_s_mag_nx <= 34'd250;
		win_e = best_e_mag_nx <= 34'd250;
		rec_s_nx = (close_s1 && sp >= 0 && win_s && (rec_s0 == NO_POS || sp < rec_s0)) ?
			sp : rec_s0;
		rec_e_nx = (close_s1 && ep >= 0 && win_e && (rec_e0 == NO_POS || ep > rec_e0)) ?
			ep : rec_e0;

		res_start = (rec_s_nx > OUT_MAX) ? OUT_MAX[24:0] : rec_s_nx[24:0];
		res_end = (rec_e_nx > OUT_MAX) ? OUT_MAX[24:0] : rec_e_nx[24:0];
		if (rec_s_nx >= 0 && rec_e_nx > rec_s_nx && rec_e_nx < $signed({8'd0, read_length}))
			res_status = ST_VALID;
		else if (rec_s_nx >= 0 && rec_e_nx == NO_POS) res_status = ST_START_ONLY;
		else if (rec_e_nx >= 0 && rec_s_nx == NO_POS) res_status = ST_END_ONLY;
		else res_status = ST_NONE;
	end

	// hold a record close in the second stage while the previous result is still held
	assign stall_b = vld_s1 && last_s1 && out_vld_q && !result_out.ready;
	assign adv_b = vld_s1 && !stall_b;
	assign pop = op_avail && !stall_b;

	assign result_out.valid = out_vld_q;
	assign result_out.interval_start = out_start_q;
	assign result_out.interval_end = out_end_q;
	assign result_out.status = out_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= '0;
			read_q <= '0;
			rec_open_q <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			if (pop) begin
				ref_q <= ref_new;
				read_q <= read_new;
				rec_open_q <= !op.last_rec;
			end
			if (!stall_b) vld_s1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			open_s1 <= open_now;
			first_s1 <= first;
			match_s1 <= op.is_match;
			close_s1 <= op.close_aln;
			last_s1 <= op.last_rec;
			flip_s1 <= op.flipped;
			nsd_ok_s1 <= nsd >= -WINDOW;
			ned_ok_s1 <= ned <= WINDOW;
			nsd_mag_s1 <= mag34(nsd);
			ned_mag_s1 <= mag34(ned);
			bsd_mag_s1 <= mag34(34'($signed(nsd[31:0])));
			bed_mag_s1 <= mag34(34'($signed(ned[31:0])));
			cand_new_s_s1 <= $signed(read_new - sc[31:0]);
			cand_new_e_s1 <= $signed(read_new - ec[31:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_s_mag_q <= '0;
			best_e_mag_q <= '0;
			cand_s_q <= NO_POS;
			cand_e_q <= NO_POS;
			rec_s_q <= NO_POS;
			rec_e_q <= NO_POS;
			out_vld_q <= 1'b0;
		end else begin
			if (adv_b) begin
				best_s_mag_q <= best_s_mag_nx;
				best_e_mag_q <= best_e_mag_nx;
				cand_s_q <= cand_s_nx;
				cand_e_q <= cand_e_nx;
				rec_s_q <= rec_s_nx;
				rec_e_q <= rec_e_nx;
			end
			if (adv_b && last_s1) out_vld_q <= 1'b1;
			else if (result_out.ready) out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_b && last_s1) begin
			out_start_q <= res_start;
			out_end_q <= res_end;
			out_status_q <= res_status;
		end
	end

	`CRIL_ASSERT_IMPLY(a_valid_ordered, clk, arst_n,
		out_vld_q && out_status_q == ST_VALID, out_start_q < out_end_q)
	`CRIL_ASSERT_NEXT(a_close_shows, clk, arst_n, adv_b && last_s1, out_vld_q)
	`CRIL_ASSERT_IMPLY(a_no_drop, clk, arst_n, out_vld_q && !result_out.ready,
		!(adv_b && last_s1))
endmodule

### hw/rtl/cigar_region_interval_locator_unit.sv
// Top level of the CIGAR region interval locator: config registers and wiring.
// Depends on cril_pkg, cril_if, cril_front, cril_queue and cril_back.
//
// Takes one CIGAR operation per clock while the queue is not full: a
// combinational decode classifies each operation into a QUEUE_DEPTH-entry
// queue, and the back end updates the running positions and distances in one
// stage and the best distances and record interval in a second, so one item
// completes per cycle unless the second stage stalls. The result of a record
// is held in an output register; the queue keeps absorbing operations while
// it waits, until full, and only the next record-closing operation stalls, in
// the second stage, until the result is taken. A closing operation passes the
// queue, the first-stage registers and the output register. Write the region
// and read length registers only while no record is in flight.
module cigar_region_interval_locator_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	cril_item_if.sink   item_in,
	cril_result_if.source result_out
);
	import cril_pkg::*;

	logic [31:0] region_start_q, region_end_q;
	logic [23:0] read_length_q;
	logic        push, q_ready, pop, op_avail;
	cril_op_t    push_op, pop_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_start_q <= '0;
			region_end_q <= '0;
			read_length_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_REGION_START: region_start_q <= cfg_wdata;
				REG_REGION_END: region_end_q <= cfg_wdata;
				REG_READ_LENGTH: read_length_q <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	cril_front u_front (
		.item_in (item_in),
		.q_ready (q_ready),
		.push    (push),
		.push_op (push_op)
	);

	cril_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_op   (push_op),
		.not_full  (q_ready),
		.pop       (pop),
		.not_empty (op_avail),
		.pop_op    (pop_op)
	);

	cril_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.region_start (region_start_q),
		.region_end   (region_end_q),
		.read_length  (read_length_q),
		.op_avail     (op_avail),
		.op           (pop_op),
		.pop          (pop),
		.result_out   (result_out)
	);
endmodule

### test/tb_interval_checker.sv
// Checker for the CIGAR region interval locator: predicts intervals per record and compares beats.
// Depends on cril_pkg and cril_if (cril_item_if, cril_result_if).
`timescale 1ns / 1ps
module tb_interval_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	cril_item_if        item,
	cril_result_if      result,
	output int          fail_count,
	output int          intervals_pending
);
	import cril_pkg::*;

	localparam longint SEARCH_WINDOW = 250;
	localparam longint SAT_POS = 16777215;

	typedef struct {
		logic signed [24:0] istart;
		logic signed [24:0] iend;
		logic [1:0]         status;
	} interval_t;

	interval_t   interval_q[$];
	logic [31:0] region_start_r, region_end_r;
	logic [23:0] read_length_r;
	logic [31:0] ref_pos, read_cur;
	longint      best_sd, best_ed, aln_sc, aln_ec, rec_s, rec_e;
	bit          rec_open;

	function automatic longint wrap32(longint v);
		return longint'($signed(v[31:0]));
	endfunction

	function automatic longint magnitude(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint reflect(longint p);
		if (p < 0)
			return p;
		return wrap32(longint'(read_length_r) - p - 1);
	endfunction

	function automatic logic signed [24:0] clip_pos(longint p);
		if (p > SAT_POS)
			p = SAT_POS;
		return p[24:0];
	endfunction

	// advance the running positions by one CIGAR op; returns 1 when a record closes
	function automatic bit locate_step(input logic [3:0] kind, input logic [27:0] len,
		input bit first, input logic [31:0] astart, input bit flip, input bit last_aln,
		input bit last_rec, output interval_t res);
		bit     eats_read, eats_ref, is_match;
		longint ds, de, sc, ec, nsd, ned, sp, ep, tmp, fs, fe, lim;
		lim = longint'(read_length_r);
		if (!rec_open) begin
			rec_open = 1;
			best_sd = lim;
			best_ed = lim;
			rec_s = -1;
			rec_e = -1;
			first = 1;
		end
		if (first) begin
			ref_pos = astart;
			read_cur = 0;
			aln_sc = -1;
			aln_ec = -1;
		end
		eats_read = kind == OP_M || kind == OP_I || kind == OP_S || kind == OP_EQ
			|| kind == OP_X;
		eats_ref = kind == OP_M || kind == OP_D || kind == OP_N || kind == OP_EQ
			|| kind == OP_X;
		is_match = kind == OP_M || kind == OP_EQ;
		if (eats_read)
			read_cur = read_cur + 32'(len);
		if (eats_ref)
			ref_pos = ref_pos + 32'(len);
		if (is_match) begin
			ds = longint'(ref_pos) - longint'(region_start_r);
			de = longint'(ref_pos) - longint'(region_end_r);
			sc = ds > 0 ? (longint'(len) < ds ? longint'(len) : ds) : 1;
			ec = de <= 0 ? 1 : (longint'(len) < de ? longint'(len) : de);
			nsd = ds - sc;
			ned = de - ec;
			if (magnitude(nsd) <= magnitude(best_sd) && nsd >= -SEARCH_WINDOW) begin
				aln_sc = wrap32(longint'(read_cur) - sc);
				best_sd = wrap32(nsd);
			end
			if (magnitude(ned) <= magnitude(best_ed) && ned <= SEARCH_WINDOW) begin
				aln_ec = wrap32(longint'(read_cur) - ec);
				best_ed = wrap32(ned);
			end
		end
		if (last_aln || last_rec) begin
			sp = aln_sc;
			ep = aln_ec;
			if (flip) begin
				tmp = reflect(sp);
				sp = reflect(ep);
				ep = tmp;
			end
			if (sp >= 0 && best_sd >= -SEARCH_WINDOW && best_sd <= SEARCH_WINDOW)
				rec_s = (rec_s == -1 || sp < rec_s) ? sp : rec_s;
			if (ep >= 0 && best_ed >= -SEARCH_WINDOW && best_ed <= SEARCH_WINDOW)
				rec_e = (rec_e == -1 || ep > rec_e) ? ep : rec_e;
		end
		if (!last_rec)
			return 0;
		fs = rec_s;
		fe = rec_e;
		if (fs >= 0 && fe > fs && fe < lim)
			res.status = ST_VALID;
		else if (fs >= 0 && fe == -1)
			res.status = ST_START_ONLY;
		else if (fe >= 0 && fs == -1)
			res.status = ST_END_ONLY;
		else
			res.status = ST_NONE;
		res.istart = clip_pos(fs);
		res.iend = clip_pos(fe);
		rec_open = 0;
		return 1;
	endfunction

	assign intervals_pending = interval_q.size();

	always @(posedge clk or negedge arst_n) begin
		interval_t got, want;
		if (!arst_n) begin
			region_start_r = '0;
			region_end_r = '0;
			read_length_r = '0;
			ref_pos = '0;
			read_cur = '0;
			best_sd = 0;
			best_ed = 0;
			aln_sc = -1;
			aln_ec = -1;
			rec_s = -1;
			rec_e = -1;
			rec_open = 0;
			fail_count = 0;
			interval_q.delete();
		end else begin
			// compare first: a beat accepted now cannot produce a result at this edge
			if (result.valid && result.ready) begin
				if (interval_q.size() == 0) begin
					$error("unexpected result beat: start %0d end %0d status %0d",
						result.interval_start, result.interval_end, result.status);
					fail_count++;
				end else begin
					want = interval_q.pop_front();
					if (result.interval_start !== want.istart) begin
						$error("interval_start: expected %0d, got %0d", want.istart,
							result.interval_start);
						fail_count++;
					end
					if (result.interval_end !== want.iend) begin
						$error("interval_end: expected %0d, got %0d", want.iend,
							result.interval_end);
						fail_count++;
					end
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						fail_count++;
					end
				end
			end
			if (item.valid && item.ready) begin
				if (locate_step(item.op_kind, item.op_len, item.first_of_alignment,
						item.aln_ref_start, item.aln_flipped, item.last_of_alignment,
						item.last_of_record, got))
					interval_q = {interval_q, got};
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_REGION_START: region_start_r = cfg_wdata;
					REG_REGION_END: region_end_r = cfg_wdata;
					REG_READ_LENGTH: read_length_r = cfg_wdata[23:0];
					default: ;
				endcase
			end
		end
	end
endmodule

### test/tb_top.sv
// Testbench top for cigar_region_interval_locator_unit: clock, reset, stimulus and verdict.
// Depends on cril_pkg, cril_if, the locator RTL and tb_interval_checker.
`timescale 1ns / 1ps
module tb_top;
	import cril_pkg::*;

	localparam logic [3:0] OP_H = 4'd5;
	localparam logic [3:0] OP_P = 4'd6;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_wdata;
	int          fail_count, intervals_pending;
	int          tx_idle, rx_idle;
	bit          hold_request;

	cril_item_if   op_ch();
	cril_result_if res_ch();

	cigar_region_interval_locator_unit u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .item_in(op_ch), .result_out(res_ch)
	);

	tb_interval_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .item(op_ch), .result(res_ch), .fail_count(fail_count),
		.intervals_pending(intervals_pending)
	);

	initial clk = 0;
	always #6 clk = ~clk;

	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end

	// result sink: random stalls, plus one long hold-off on request
	initial begin
		bit held;
		held = 0;
		res_ch.ready = 0;
		forever begin
			@(negedge clk);
			if (hold_request && !held) begin
				held = 1;
				res_ch.ready = 0;
				repeat (400) @(negedge clk);
			end
			res_ch.ready = $urandom_range(0, 99) >= rx_idle;
		end
	end

	task automatic send_op(input logic [3:0] kind, input logic [27:0] len, input bit first,
		input logic [31:0] astart, input bit flip, input bit last_aln, input bit last_rec);
		while ($urandom_range(0, 99) < tx_idle) begin
			op_ch.valid = 0;
			@(negedge clk);
		end
		op_ch.op_kind = kind;
		op_ch.op_len = len;
		op_ch.first_of_alignment = first;
		op_ch.aln_ref_start = astart;
		op_ch.aln_flipped = flip;
		op_ch.last_of_alignment = last_aln;
		op_ch.last_of_record = last_rec;
		op_ch.valid = 1;
		do @(posedge clk); while (!op_ch.ready);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_wr_en = 1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_wr_en = 0;
	endtask

	// drop valid, wait for every interval, then let the pipeline empty
	task automatic settle();
		op_ch.valid = 0;
		while (intervals_pending != 0) @(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	function automatic logic [3:0] pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return OP_M;
		if (r < 50) return OP_EQ;
		if (r < 58) return OP_X;
		if (r < 66) return OP_I;
		if (r < 74) return OP_D;
		if (r < 80) return OP_N;
		if (r < 88) return OP_S;
		if (r < 93) return OP_H;
		if (r < 97) return OP_P;
		return 4'($urandom_range(9, 15));
	endfunction

	// one record of well-formed alignments around the region; returns ops sent
	task automatic send_record(input logic [31:0] rs, output int sent);
		int          n_aln, n_ops;
		logic [31:0] astart;
		logic [27:0] len;
		bit          flip;
		sent = 0;
		n_aln = $urandom_range(1, 3);
		for (int a = 0; a < n_aln; a++) begin
			n_ops = $urandom_range(1, 6);
			astart = rs + $urandom_range(0, 1200) - 600;
			flip = $urandom_range(0, 1);
			for (int o = 0; o < n_ops; o++) begin
				len = ($urandom_range(0, 19) == 0) ? 28'($urandom) : 28'($urandom_range(0, 400));
				send_op(pick_kind(), len, o == 0, astart, flip, o == n_ops - 1,
					a == n_aln - 1 && o == n_ops - 1);
				sent++;
			end
		end
	endtask

	task automatic run_phase(input int n_items, input logic [31:0] rs);
		int sent, count;
		count = 0;
		while (count < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				send_op(4'($urandom), 28'($urandom), $urandom_range(0, 1), $urandom,
					$urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 3) == 0);
				count++;
			end else begin
				send_record(rs, sent);
				count += sent;
			end
		end
		// close whatever record noise left open
		send_op(OP_M, 28'd10, 1, rs, 0, 1, 1);
		settle();
	endtask

	task automatic set_region(input logic [31:0] rs, input logic [31:0] re,
		input logic [23:0] rl);
		write_reg(REG_REGION_START, rs);
		write_reg(REG_REGION_END, re);
		write_reg(REG_READ_LENGTH, {8'd0, rl});
	endtask

	initial begin
		logic [31:0] rs;
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_index = REG_REGION_START;
		cfg_wdata = '0;
		op_ch.valid = 0;
		op_ch.op_kind = OP_M;
		op_ch.op_len = '0;
		op_ch.first_of_alignment = 0;
		op_ch.aln_ref_start = '0;
		op_ch.aln_flipped = 0;
		op_ch.last_of_alignment = 0;
		op_ch.last_of_record = 0;
		tx_idle = 33;
		rx_idle = 61;
		hold_request = 0;
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: every op kind, extremes of the fields, flipped and empty alignments
		set_region(32'd1000, 32'd1300, 24'd2000);
		send_op(OP_M, 28'd600, 1, 32'd900, 0, 1, 1);
		send_op(OP_S, 28'd50, 1, 32'd950, 0, 0, 0);
		send_op(OP_M, 28'd200, 0, 32'd0, 0, 0, 0);
		send_op(OP_I, 28'd10, 0, 32'd0, 0, 0, 0);
		send_op(OP_D, 28'd5, 0, 32'd0, 0, 0, 0);
		send_op(OP_N, 28'd3, 0, 32'd0, 0, 0, 0);
		send_op(OP_H, 28'd4, 0, 32'd0, 0, 0, 0);
		send_op(OP_P, 28'd2, 0, 32'd0, 0, 0, 0);
		send_op(OP_EQ, 28'd300, 0, 32'd0, 0, 0, 0);
		send_op(OP_X, 28'd20, 0, 32'd0, 1, 1, 0);
		send_op(4'd9, 28'd7, 1, 32'd1100, 0, 0, 0);
		send_op(OP_EQ, 28'd400, 0, 32'd0, 1, 0, 1);
		send_op(4'd15, 28'hFFFFFFF, 1, 32'hFFFFFFFF, 1, 1, 1);
		send_op(OP_M, 28'hFFFFFFF, 1, 32'hFFFFFFFF, 0, 0, 1);
		send_op(OP_I, 28'd5, 0, 32'd0, 0, 0, 1);
		send_op(OP_M, 28'd1, 1, 32'd1299, 1, 1, 0);
		send_op(OP_M, 28'd0, 0, 32'd999, 0, 1, 1);
		settle();

		rs = $urandom_range(300, 100000);
		set_region(rs, rs + $urandom_range(0, 900), 24'($urandom_range(500, 5000)));
		run_phase(150, rs);

		// extremes of the registers
		set_region(32'd0, 32'hFFFFFFFF, 24'hFFFFFF);
		run_phase(60, 32'd0);
		set_region(32'hFFFFFFFF, 32'd0, 24'd0);
		run_phase(60, 32'hFFFFFFFF);

		tx_idle = 61;
		rx_idle = 33;
		rs = $urandom;
		set_region(rs, rs + $urandom_range(0, 2000), 24'($urandom_range(200, 3000)));
		run_phase(220, rs);

		tx_idle = 0;
		rx_idle = 0;
		rs = $urandom_range(1000, 1 << 30);
		set_region(rs, rs + $urandom_range(0, 600), 24'($urandom_range(100, 4000)));
		hold_request = 1;
		run_phase(300, rs);

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
